/* rtl/console_line_editor_defines.svh */
// ----------------------------------------------------------------------------
// Console line editor assertion macros
// Shorthand for the concurrent checks on the editor's ports. Each macro
// expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define CLE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define CLE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define CLE_ASSERT_AFTER_RESET(name, cons, msg) \
  name: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cle_pkg.sv */
// ----------------------------------------------------------------------------
// Console line editor package
// Shared sizes, key and character codes, register indexes and the command
// and result word types.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Line store size and the width of a position in it.
  localparam int LINE_BYTES = 32;
  localparam int POS_W      = $clog2(LINE_BYTES);

  localparam int CHAR_W     = 8;
  localparam int CAP_W      = 6;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ECHO     = 2'd1;
  localparam logic [CAP_W-1:0]     CAP_RESET         = 6'd32;

  // Key codes.
  localparam logic [CHAR_W-1:0] KEY_ENTER  = 8'd13;
  localparam logic [CHAR_W-1:0] KEY_BKSP   = 8'd8;
  localparam logic [CHAR_W-1:0] KEY_EXT    = 8'd0;
  localparam logic [CHAR_W-1:0] SCAN_RIGHT = 8'h4D;
  localparam logic [CHAR_W-1:0] SCAN_LEFT  = 8'h4B;

  // Characters produced by the editor.
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;

  localparam logic DEST_SCREEN = 1'b0;
  localparam logic DEST_LINE   = 1'b1;

  // Command queue between front and back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Result queue feeding the output port.
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_BKSP,
    OP_ENTER,
    OP_RIGHT,
    OP_LEFT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              dest;
    logic              last;
  } res_t;

endpackage

/* rtl/cle_front.sv */
// ----------------------------------------------------------------------------
// Console line editor front end
// Accepts key words, sorts them into editing commands, drops unknown extended
// keys and holds the commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module cle_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [cle_pkg::CHAR_W-1:0] in_ascii_code,
  input  logic [cle_pkg::CHAR_W-1:0] in_scan_code,
  output logic                      cmd_valid,
  output cle_pkg::cmd_t             cmd,
  input  logic                      cmd_pop
);
  import cle_pkg::*;

  cmd_t                  q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  keep;
  op_t                   op;
  logic                  wr_en;
  logic                  rd_en;

  // Extended keys other than the two arrows are dropped here.
  always_comb begin
    keep = 1'b1;
    op   = OP_PRINT;
    case (in_ascii_code)
      KEY_ENTER: op = OP_ENTER;
      KEY_BKSP:  op = OP_BKSP;
      KEY_EXT: begin
        case (in_scan_code)
          SCAN_RIGHT: op = OP_RIGHT;
          SCAN_LEFT:  op = OP_LEFT;
          default:    keep = 1'b0;
        endcase
      end
      default: op = OP_PRINT;
    endcase
  end

  assign in_full   = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = in_push && !in_full && keep;
  assign rd_en     = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                   : wr_ptr_r + CMDQ_PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                   : rd_ptr_r + CMDQ_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CMDQ_CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= '{op: op, ch: in_ascii_code};
    end
  end

endmodule

/* rtl/cle_resq.sv */
// ----------------------------------------------------------------------------
// Console line editor result queue
// Small queue of result words between the back end and the output port.
// ----------------------------------------------------------------------------
module cle_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cle_pkg::res_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output cle_pkg::res_t dout
);
  import cle_pkg::*;

  res_t                  q_r [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RESQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RESQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  wr_en;
  logic                  rd_en;

  assign full  = (cnt_r == RESQ_CNT_W'(RESQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = q_r[rd_ptr_r];
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0
                   : wr_ptr_r + RESQ_PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0
                   : rd_ptr_r + RESQ_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + RESQ_CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - RESQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* rtl/cle_back.sv */
// ----------------------------------------------------------------------------
// Console line editor back end
// Sequencer that runs one editing command at a time against the line store,
// cursor and length; one result word per cycle at most, none while res_full.
// ----------------------------------------------------------------------------
module cle_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  input  cle_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  input  logic [cle_pkg::CAP_W-1:0] cap,
  input  logic                      mask,
  output logic                      res_push,
  output cle_pkg::res_t             res,
  input  logic                      res_full
);
  import cle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ONE,
    S_RIGHT,
    S_CR,
    S_LF,
    S_DATA,
    S_ZERO,
    S_BS,
    S_SHIFT,
    S_SPACE,
    S_BACK
  } state_t;

  function automatic logic [CHAR_W-1:0] shown(input logic [CHAR_W-1:0] c,
                                              input logic             m);
    return m ? CH_STAR : c;
  endfunction

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   cursor_r, cursor_nxt;
  logic [POS_W-1:0]   len_r, len_nxt;
  logic [POS_W-1:0]   j_r, j_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;

  logic [CHAR_W-1:0]  mem_r [LINE_BYTES];
  logic [CHAR_W-1:0]  rd_data_r;
  logic               mem_we;
  logic [POS_W-1:0]   mem_wa;
  logic [CHAR_W-1:0]  mem_wd;
  logic               mem_re;
  logic [POS_W-1:0]   mem_ra;

  logic [CAP_W-1:0]   cap_eff;
  logic               fits;
  logic [POS_W-1:0]   cur_inc;
  logic [POS_W-1:0]   j_inc;
  logic               more;
  logic               emit;
  logic               go;

  // Capacities above the store size act as the store size.
  assign cap_eff = (cap > CAP_W'(LINE_BYTES)) ? CAP_W'(LINE_BYTES) : cap;
  assign fits    = (CAP_W'(cursor_r) + CAP_W'(1)) < cap_eff;
  assign cur_inc = cursor_r + POS_W'(1);
  assign j_inc   = j_r + POS_W'(1);
  assign more    = ((POS_W+1)'(j_r) + (POS_W+1)'(1)) < (POS_W+1)'(len_r);
  assign go      = !res_full;
  assign res_push = emit && go;

  always_comb begin
    state_nxt  = state_r;
    cursor_nxt = cursor_r;
    len_nxt    = len_r;
    j_nxt      = j_r;
    char_nxt   = char_r;
    cmd_pop    = 1'b0;
    emit       = 1'b0;
    res        = '{ch: CH_NUL, dest: DEST_SCREEN, last: 1'b0};
    mem_we     = 1'b0;
    mem_wa     = cursor_r;
    mem_wd     = cmd.ch;
    mem_re     = 1'b0;
    mem_ra     = cursor_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_PRINT: begin
              if (fits) begin
                mem_we     = 1'b1;
                char_nxt   = shown(cmd.ch, mask);
                cursor_nxt = cur_inc;
                if (cur_inc > len_r) begin
                  len_nxt = cur_inc;
                end
                state_nxt  = S_ONE;
              end
            end
            OP_BKSP: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - POS_W'(1);
                j_nxt      = cursor_r - POS_W'(1);
                state_nxt  = S_BS;
              end
            end
            OP_ENTER: state_nxt = S_CR;
            OP_RIGHT: begin
              if (cursor_r < len_r) begin
                mem_re    = 1'b1;
                state_nxt = S_RIGHT;
              end
            end
            OP_LEFT: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - POS_W'(1);
                char_nxt   = CH_BS;
                state_nxt  = S_ONE;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ONE: begin
        emit = 1'b1;
        res  = '{ch: char_r, dest: DEST_SCREEN, last: 1'b1};
        if (go) begin
          state_nxt = S_IDLE;
        end
      end
      S_RIGHT: begin
        emit = 1'b1;
        res  = '{ch: shown(rd_data_r, mask), dest: DEST_SCREEN, last: 1'b1};
        if (go) begin
          cursor_nxt = cur_inc;
          state_nxt  = S_IDLE;
        end
      end
      S_CR: begin
        emit = 1'b1;
        res  = '{ch: CH_CR, dest: DEST_SCREEN, last: 1'b0};
        if (go) begin
          state_nxt = S_LF;
        end
      end
      S_LF: begin
        emit = 1'b1;
        res  = '{ch: CH_LF, dest: DEST_SCREEN, last: 1'b0};
        if (go) begin
          if (len_r != '0) begin
            mem_re    = 1'b1;
            mem_ra    = '0;
            j_nxt     = '0;
            state_nxt = S_DATA;
          end else begin
            state_nxt = S_ZERO;
          end
        end
      end
      S_DATA: begin
        emit = 1'b1;
        res  = '{ch: rd_data_r, dest: DEST_LINE, last: 1'b0};
        if (go) begin
          j_nxt = j_inc;
          if (more) begin
            mem_re = 1'b1;
            mem_ra = j_inc;
          end else begin
            state_nxt = S_ZERO;
          end
        end
      end
      S_ZERO: begin
        emit = 1'b1;
        res  = '{ch: CH_NUL, dest: DEST_LINE, last: 1'b1};
        if (go) begin
          cursor_nxt = '0;
          len_nxt    = '0;
          state_nxt  = S_IDLE;
        end
      end
      S_BS: begin
        emit = 1'b1;
        res  = '{ch: CH_BS, dest: DEST_SCREEN, last: 1'b0};
        if (go) begin
          if (more) begin
            mem_re    = 1'b1;
            mem_ra    = j_inc;
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_SPACE;
          end
        end
      end
      S_SHIFT: begin
        // The character read from the next cell moves down one place.
        emit = 1'b1;
        res  = '{ch: shown(rd_data_r, mask), dest: DEST_SCREEN, last: 1'b0};
        if (go) begin
          mem_we = 1'b1;
          mem_wa = j_r;
          mem_wd = rd_data_r;
          j_nxt  = j_inc;
          if (((POS_W+1)'(j_inc) + (POS_W+1)'(1)) < (POS_W+1)'(len_r)) begin
            mem_re = 1'b1;
            mem_ra = j_inc + POS_W'(1);
          end else begin
            state_nxt = S_SPACE;
          end
        end
      end
      S_SPACE: begin
        emit = 1'b1;
        res  = '{ch: CH_SPACE, dest: DEST_SCREEN, last: 1'b0};
        if (go) begin
          j_nxt     = len_r - cursor_r;
          state_nxt = S_BACK;
        end
      end
      S_BACK: begin
        emit = 1'b1;
        res  = '{ch: CH_BS, dest: DEST_SCREEN, last: (j_r == POS_W'(1))};
        if (go) begin
          j_nxt = j_r - POS_W'(1);
          if (j_r == POS_W'(1)) begin
            len_nxt   = len_r - POS_W'(1);
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= '0;
      len_r    <= '0;
      j_r      <= '0;
      char_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      len_r    <= len_nxt;
      j_r      <= j_nxt;
      char_r   <= char_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[mem_ra];
    end
  end

endmodule

/* rtl/console_line_editor.sv */
// ----------------------------------------------------------------------------
// Console line editor
// Keystroke-driven line editor with echo: keeps a line buffer, cursor and
// length, echoes edits to the screen and delivers finished lines.
// ----------------------------------------------------------------------------
// Path: an accepted key word waits in the front-end command queue, is decoded
//   by the back end into its state register, and its result words pass
//   through the result queue to the output. Pacing: a key is decoded only
//   after the previous key's result words are all emitted; the back-end
//   sequencer and its single line-store read port set this pace.
// Reset: synchronous; both queues empty, cursor and length zero, capacity 32,
//   masking off. The line store is not cleared.
module console_line_editor (
  input  logic                           clk,
  input  logic                           rst_n,
  // Key words.
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [cle_pkg::CHAR_W-1:0]     in_ascii_code,
  input  logic [cle_pkg::CHAR_W-1:0]     in_scan_code,
  // Result words.
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [cle_pkg::CHAR_W-1:0]     out_char,
  output logic                           out_destination,
  output logic                           out_last_of_run,
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cle_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cle_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cle_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             mask_r;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;
  logic res_push;
  logic res_full;
  res_t res_head;

  // The register file takes a write in any cycle. Writes to an index past
  // the last register are accepted and have no effect.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      mask_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx)
        CFG_LINE_CAPACITY: cap_r  <= cfg_wdata[CAP_W-1:0];
        CFG_MASK_ECHO:     mask_r <= cfg_wdata[0];
        default:           cap_r  <= cap_r;
      endcase
    end
  end

  // The front end classifies each key word and queues an editing command.
  // Keys that have no effect at all (unknown extended keys) are dropped
  // here, so they never occupy the back end.
  cle_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_ascii_code (in_ascii_code),
    .in_scan_code  (in_scan_code),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // The back end runs one command at a time. It owns the line store,
  // cursor and length, and emits at most one result word per cycle, holding
  // its place whenever the result queue is full.
  cle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cap       (cap_r),
    .mask      (mask_r),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // The result queue decouples the sequencer from the consumer; the head
  // word is presented directly on the output ports.
  cle_resq u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (res_head)
  );

  assign out_char        = res_head.ch;
  assign out_destination = res_head.dest;
  assign out_last_of_run = res_head.last;

endmodule

/* rtl/cle_checker.sv */
// ----------------------------------------------------------------------------
// Console line editor port checker
// Concurrent checks on the editor's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "console_line_editor_defines.svh"

module cle_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_full,
  input logic                       out_empty,
  input logic                       out_pop,
  input logic [cle_pkg::CHAR_W-1:0] out_char,
  input logic                       out_destination,
  input logic                       out_last_of_run
);
  import cle_pkg::*;

  // Both queues come out of reset empty.
  `CLE_ASSERT_AFTER_RESET(a_reset_empty, out_empty && !in_full, "queues not empty after reset")

  // A finished line always ends with its zero terminator.
  `CLE_ASSERT_NOW(a_line_end_zero, !out_empty && out_destination && out_last_of_run, out_char == CH_NUL, "line data ends without terminator")

  // Stored line characters are never zero, so only the terminator is zero.
  `CLE_ASSERT_NOW(a_line_data_nonzero, !out_empty && out_destination && !out_last_of_run, out_char != CH_NUL, "zero inside line data")

  // The carriage return of Enter is never the final word of a key.
  `CLE_ASSERT_NOW(a_echo_last_not_cr, !out_empty && !out_destination && out_last_of_run, out_char != CH_CR, "echo run ends in carriage return")

  // A waiting word holds until it is taken.
  `CLE_ASSERT_NEXT(a_hold_stalled, !out_empty && !out_pop, !out_empty && $stable(out_char) && $stable(out_destination) && $stable(out_last_of_run), "stalled word changed")

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

/* dv/tb_console_line_editor.sv */
// ----------------------------------------------------------------------------
// Console line editor testbench
// Sends keystroke words into the editor and predicts every echo and line-data
// word with a behavioral copy of the editor kept inside the bench. Directed
// tests cover empty-line corner cases, capacity limits and masked echo. A
// full-line redraw and four randomized phases follow, each phase with its own
// settings and its own mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_console_line_editor;
  import cle_pkg::*;

  // Cycles to let pass once the last expected word has arrived. Keys that
  // cause no output may still sit in the command queue at that point.
  localparam int DRAIN_CYCLES = 16;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [CHAR_W-1:0]     in_ascii_code = '0;
  logic [CHAR_W-1:0]     in_scan_code = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_destination;
  logic                  out_last_of_run;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_LINE_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  console_line_editor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_ascii_code   (in_ascii_code),
    .in_scan_code    (in_scan_code),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_char        (out_char),
    .out_destination (out_destination),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the editor: line contents, cursor, length and the two
  // registers. Only entries below the line length are ever read, and those
  // have always been written by a printable key first.
  logic [CHAR_W-1:0] line_copy [LINE_BYTES];
  logic [POS_W-1:0]  cursor_copy = '0;
  logic [POS_W-1:0]  length_copy = '0;
  logic [CAP_W-1:0]  capacity_copy = CAP_RESET;
  logic              mask_copy = 1'b0;

  // Words the editor still owes us, oldest first.
  res_t pending_words[$];

  // Idle percentages for the sender (gap before a key) and the receiver
  // (pop held low in a cycle).
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  int keys_sent = 0;
  int words_checked = 0;
  int mismatch_count = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic logic [CHAR_W-1:0] echo_of(input logic [CHAR_W-1:0] c);
    return mask_copy ? CH_STAR : c;
  endfunction

  function automatic void owe_word(input logic [CHAR_W-1:0] c, input logic dest);
    res_t w;
    w.ch   = c;
    w.dest = dest;
    w.last = 1'b0;
    pending_words.push_back(w);
  endfunction

  // Applies one accepted key to the shadow editor and queues the words it
  // must produce. The final word of a key carries the last-of-run flag.
  function automatic void editor_apply_key(input logic [CHAR_W-1:0] ascii,
                                           input logic [CHAR_W-1:0] scan);
    int   cap;
    int   cur;
    int   len;
    int   first;
    int   j;
    res_t w;
    first = pending_words.size();
    // Capacities above the store size behave as the store size.
    cap = (capacity_copy > LINE_BYTES) ? LINE_BYTES : int'(capacity_copy);
    cur = int'(cursor_copy);
    len = int'(length_copy);
    if (ascii == KEY_ENTER) begin
      // Enter: CR and LF to the screen, then the line and a NUL as line data.
      owe_word(CH_CR, DEST_SCREEN);
      owe_word(CH_LF, DEST_SCREEN);
      for (j = 0; j < len; j++) owe_word(line_copy[j], DEST_LINE);
      owe_word(CH_NUL, DEST_LINE);
      cur = 0;
      len = 0;
    end else if (ascii == KEY_BKSP) begin
      // Backspace: step back, shift the tail left while redrawing it, blank
      // the old last column and walk the screen cursor back into place.
      if (cur != 0) begin
        cur--;
        owe_word(CH_BS, DEST_SCREEN);
        for (j = cur; j + 1 < len; j++) begin
          line_copy[j] = line_copy[j + 1];
          owe_word(echo_of(line_copy[j]), DEST_SCREEN);
        end
        owe_word(CH_SPACE, DEST_SCREEN);
        for (j = len; j > cur; j--) owe_word(CH_BS, DEST_SCREEN);
        if (len != 0) len--;
      end
    end else if (ascii == KEY_EXT) begin
      // Only the two arrows do anything among the extended keys.
      if (scan == SCAN_RIGHT) begin
        if (cur < len) begin
          owe_word(echo_of(line_copy[cur]), DEST_SCREEN);
          cur = (cur + 1) % LINE_BYTES;
        end
      end else if (scan == SCAN_LEFT) begin
        if (cur != 0) begin
          cur--;
          owe_word(CH_BS, DEST_SCREEN);
        end
      end
    end else begin
      // Printable: overwrite at the cursor while one slot stays free.
      if (cur + 1 < cap) begin
        line_copy[cur] = ascii;
        owe_word(echo_of(ascii), DEST_SCREEN);
        cur = (cur + 1) % LINE_BYTES;
      end
      if (cur > len) len = cur;
    end
    cursor_copy = cur[POS_W-1:0];
    length_copy = len[POS_W-1:0];
    if (pending_words.size() > first) begin
      w = pending_words.pop_back();
      w.last = 1'b1;
      pending_words.push_back(w);
    end
  endfunction

  // Sends one key word, after a random gap when the sender is set to idle.
  // The push stays high on return so that back-to-back keys need no toggle.
  task automatic send_key(input logic [CHAR_W-1:0] ascii, input logic [CHAR_W-1:0] scan);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_ascii_code <= ascii;
    in_scan_code  <= scan;
    @(posedge clk);
    while (in_full) @(posedge clk);
    editor_apply_key(ascii, scan);
    keys_sent++;
  endtask

  // Holds the sender off until every owed word has come, then lets the
  // editor finish any keys that produce nothing.
  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers. Only called while the editor is idle.
  task automatic set_config(input logic [CAP_W-1:0] cap, input logic mask);
    cfg_valid <= 1'b1;
    cfg_idx   <= CFG_LINE_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    capacity_copy = cap;
    cfg_idx   <= CFG_MASK_ECHO;
    cfg_wdata <= {{(CFG_DATA_W - 1){1'b0}}, mask};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mask_copy = mask;
    cfg_valid <= 1'b0;
  endtask

  // Result side: compare each popped word with the oldest owed word and
  // choose the next cycle's pop at random.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        words_checked++;
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("word 0x%02h dest %0b arrived with nothing owed",
                                    out_char, out_destination));
        end else begin
          want = pending_words.pop_front();
          if (out_char !== want.ch) begin
            report_mismatch($sformatf("char 0x%02h, expected 0x%02h", out_char, want.ch));
          end
          if (out_destination !== want.dest) begin
            report_mismatch($sformatf("destination %0b, expected %0b",
                                      out_destination, want.dest));
          end
          if (out_last_of_run !== want.last) begin
            report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                      out_last_of_run, want.last));
          end
        end
      end
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Empty-line corner cases, the extremes of the key codes, arrows, a
  // backspace at the end of a line and a retyped character, at reset settings.
  task automatic test_basic_edits();
    send_key(KEY_ENTER, 8'h00);
    send_key(KEY_BKSP, 8'h00);
    send_key(KEY_EXT, SCAN_LEFT);
    send_key(KEY_EXT, SCAN_RIGHT);
    send_key(KEY_EXT, 8'hFF);
    send_key(8'h01, 8'h00);
    send_key(8'hFF, 8'hFF);
    send_key(8'h61, SCAN_LEFT);
    send_key(KEY_EXT, SCAN_RIGHT);
    send_key(KEY_EXT, SCAN_LEFT);
    send_key(KEY_EXT, SCAN_RIGHT);
    send_key(KEY_BKSP, 8'h00);
    send_key(8'h5A, 8'h00);
    send_key(KEY_ENTER, 8'h00);
  endtask

  // Capacity of two holds one character; one and zero hold none.
  task automatic test_capacity_limits();
    wait_drained();
    set_config(6'd2, 1'b0);
    send_key(8'h78, 8'h00);
    send_key(8'h79, 8'h00);
    wait_drained();
    set_config(6'd1, 1'b0);
    send_key(8'h71, 8'h00);
    wait_drained();
    set_config(6'd0, 1'b0);
    send_key(8'h72, 8'h00);
    send_key(KEY_ENTER, 8'h00);
  endtask

  // Echoes become asterisks, including the backspace redraw, while the
  // finished line still comes out in clear.
  task automatic test_masked_echo();
    wait_drained();
    set_config(6'd63, 1'b1);
    send_key(8'h6B, 8'h00);
    send_key(8'h6D, 8'h00);
    send_key(KEY_EXT, SCAN_LEFT);
    send_key(KEY_BKSP, 8'h00);
    send_key(KEY_ENTER, 8'h00);
  endtask

  function automatic logic [CHAR_W-1:0] random_printable();
    logic [CHAR_W-1:0] c;
    do begin
      c = CHAR_W'($urandom_range(255, 1));
    end while (c == KEY_BKSP || c == KEY_ENTER);
    return c;
  endfunction

  // Fills a full line, walks back to the second column and deletes there,
  // which is the longest redraw the editor can produce.
  task automatic test_full_line_redraw();
    wait_drained();
    set_config(6'd32, 1'($urandom_range(1)));
    send_key(KEY_ENTER, CHAR_W'($urandom));
    repeat (LINE_BYTES) send_key(random_printable(), CHAR_W'($urandom));
    repeat (LINE_BYTES - 2) send_key(KEY_EXT, SCAN_LEFT);
    send_key(KEY_BKSP, CHAR_W'($urandom));
    send_key(KEY_ENTER, CHAR_W'($urandom));
  endtask

  // Mostly editing traffic with random content: typing, deletes, arrows and
  // an Enter now and then, plus unknown extended keys and raw noise.
  function automatic void pick_key(output logic [CHAR_W-1:0] ascii,
                                   output logic [CHAR_W-1:0] scan);
    int roll;
    roll  = $urandom_range(99);
    scan  = CHAR_W'($urandom);
    ascii = random_printable();
    if (roll >= 50 && roll < 64) begin
      ascii = KEY_BKSP;
    end else if (roll >= 64 && roll < 73) begin
      ascii = KEY_EXT;
      scan  = SCAN_RIGHT;
    end else if (roll >= 73 && roll < 83) begin
      ascii = KEY_EXT;
      scan  = SCAN_LEFT;
    end else if (roll >= 83 && roll < 89) begin
      ascii = KEY_ENTER;
    end else if (roll >= 89 && roll < 94) begin
      ascii = KEY_EXT;
    end else if (roll >= 94) begin
      ascii = CHAR_W'($urandom);
    end
  endfunction

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_keys,
                                  input logic [CAP_W-1:0] cap, input logic mask);
    logic [CHAR_W-1:0] ascii;
    logic [CHAR_W-1:0] scan;
    wait_drained();
    set_config(cap, mask);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    repeat (n_keys) begin
      pick_key(ascii, scan);
      send_key(ascii, scan);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_edits();
    test_capacity_limits();
    test_masked_echo();
    test_full_line_redraw();
    run_random_phase(0, 0, 45, 6'd32, 1'b0);
    run_random_phase(47, 0, 45, 6'd63, 1'b1);
    run_random_phase(0, 47, 45, CAP_W'($urandom_range(12, 2)), 1'b0);
    run_random_phase(14, 14, 45, CAP_W'($urandom_range(32, 2)), 1'b1);
    wait_drained();

    $display("Run covered %0d keys and %0d result words over capacities 0 to 63,",
             keys_sent, words_checked);
    $display("masked and clear echo, and four sender/receiver idle patterns.");
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Timeout with %0d words still owed", pending_words.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
